// ===== hw/rtl/shi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shi_pkg;

  localparam int IssueWidthDef = 4;
  localparam int LaneW         = 3;
  localparam int RegW          = 8;
  localparam int AgeW          = 32;
  localparam int CfgIdxW       = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MEM_FWD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXE_FWD = 2'd1;

  // one pipeline slot: decode, EX or MA
  typedef struct packed {
    logic            valid;
    logic [RegW-1:0] ra;
    logic [RegW-1:0] rb;
    logic [RegW-1:0] rd;
    logic            ua;
    logic            ub;
    logic            ud;
    logic            rf;
    logic            wf;
    logic            ld;
    logic [AgeW-1:0] age;
  } slot_t;

  typedef struct packed {
    logic mem_fwd;
    logic exe_fwd;
  } fwd_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shi_hazard_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parallel interlock evaluation for one closed group.
module shi_hazard_check #(
  parameter int ISSUE_WIDTH = shi_pkg::IssueWidthDef
) (
  input  shi_pkg::slot_t    dec_i [ISSUE_WIDTH],
  input  shi_pkg::slot_t    exe_i [ISSUE_WIDTH],
  input  shi_pkg::slot_t    mem_i [ISSUE_WIDTH],
  input  shi_pkg::fwd_cfg_t cfg_i,
  output logic [ISSUE_WIDTH-1:0] fin_o
);

  // candidates in scan order: per lane MA, EX, group
  localparam int NCand = 3 * ISSUE_WIDTH;

  localparam logic [1:0] KIND_A    = 2'd0;
  localparam logic [1:0] KIND_B    = 2'd1;
  localparam logic [1:0] KIND_FLAG = 2'd2;

  shi_pkg::slot_t   cand [NCand];
  logic [NCand-1:0] cand_stall;
  logic [NCand-1:0] gt [NCand];  // gt[k][m]: cand k younger than cand m
  logic [ISSUE_WIDTH-1:0] own;

  function automatic logic matches_kind(shi_pkg::slot_t p, shi_pkg::slot_t c,
                                        logic [1:0] kind);
    logic hit;
    case (kind)
      KIND_A:    hit = c.ua && p.ud && (p.rd == c.ra);
      KIND_B:    hit = c.ub && p.ud && (p.rd == c.rb);
      KIND_FLAG: hit = c.rf && p.wf;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  always_comb begin
    for (int j = 0; j < ISSUE_WIDTH; j++) begin
      cand[3*j]         = mem_i[j];
      cand[3*j+1]       = exe_i[j];
      cand[3*j+2]       = dec_i[j];
      cand_stall[3*j]   = !cfg_i.mem_fwd;
      cand_stall[3*j+1] = !(cfg_i.exe_fwd && !exe_i[j].ld);
      cand_stall[3*j+2] = 1'b1;
    end
  end

  // pairwise age order, shared by every consumer and operand
  always_comb begin
    for (int k = 0; k < NCand; k++) begin
      for (int m = 0; m < NCand; m++) begin
        gt[k][m] = cand[k].age > cand[m].age;
      end
    end
  end

  // youngest older producer: the max age, earliest in scan order on ties
  always_comb begin
    logic [NCand-1:0] prod;
    logic             best;
    logic             hit_any;
    int               ci;
    for (int i = 0; i < ISSUE_WIDTH; i++) begin
      ci      = 3*i + 2;
      hit_any = 1'b0;
      for (int t = 0; t < 3; t++) begin
        for (int k = 0; k < NCand; k++) begin
          prod[k] = cand[k].valid && gt[ci][k] && (k != ci) &&
                    matches_kind(cand[k], dec_i[i], 2'(t));
        end
        for (int k = 0; k < NCand; k++) begin
          best = prod[k];
          for (int m = 0; m < NCand; m++) begin
            if (m < k && prod[m] && !gt[k][m]) begin
              best = 1'b0;
            end
            if (m > k && prod[m] && gt[m][k]) begin
              best = 1'b0;
            end
          end
          hit_any = hit_any | (best && cand_stall[k]);
        end
      end
      own[i] = dec_i[i].valid && hit_any;
    end
  end

  // a stalled lane drags every younger occupied lane with it
  always_comb begin
    for (int j = 0; j < ISSUE_WIDTH; j++) begin
      fin_o[j] = own[j];
      for (int i = 0; i < ISSUE_WIDTH; i++) begin
        if (own[i] && dec_i[j].valid && gt[3*j+2][3*i+2]) begin
          fin_o[j] = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/superscalar_hazard_interlock_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decode interlock for an in-order superscalar pipeline with ISSUE_WIDTH
// lanes plus EX and MA stages. Decoded instructions arrive one beat per lane;
// a beat with group_end_i closes the group (a beat whose lane is out of range
// is dropped, but still closes the group if so marked). Beats are taken in
// the cycle they are offered, except while a closed group still waits for the
// result serializer: then in_ready_o stays low until the serializer frees up.
// The closing beat is evaluated by the parallel comparator array in the
// following cycle once the serializer is free, and its ISSUE_WIDTH results
// (one per lane, in lane order, last_o on the highest lane) then leave one
// beat per cycle while out_ready_i is high. A new closed group is
// evaluated no earlier than the previous group's last result leaves, so the
// result serializer sets the sustained rate, while beats of the next
// group keep flowing into the decode slots as results drain. Forwarding
// enables are written through the cfg port (index 0: MA forwarding, index 1:
// EX forwarding for non-loads), both off after reset; write them only while
// the block is idle.
module superscalar_hazard_interlock_top #(
  parameter int ISSUE_WIDTH = shi_pkg::IssueWidthDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [shi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire                            cfg_data_i,
  // instruction beats
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [shi_pkg::LaneW-1:0]      lane_i,
  input  wire  [shi_pkg::RegW-1:0]       src_a_reg_i,
  input  wire                            src_a_used_i,
  input  wire  [shi_pkg::RegW-1:0]       src_b_reg_i,
  input  wire                            src_b_used_i,
  input  wire  [shi_pkg::RegW-1:0]       dest_reg_i,
  input  wire                            dest_used_i,
  input  wire                            reads_flags_i,
  input  wire                            writes_flags_i,
  input  wire                            is_load_i,
  input  wire  [shi_pkg::AgeW-1:0]       age_i,
  input  wire                            group_end_i,
  // per-lane decisions
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [shi_pkg::LaneW-1:0]      out_lane_o,
  output logic                           stalled_o,
  output logic                           occupied_o,
  output logic                           last_o
);

  localparam int IdxW = (ISSUE_WIDTH > 1) ? $clog2(ISSUE_WIDTH) : 1;

  // pipeline slots
  shi_pkg::slot_t dec_q [ISSUE_WIDTH];
  shi_pkg::slot_t dec_d [ISSUE_WIDTH];
  shi_pkg::slot_t exe_q [ISSUE_WIDTH];
  shi_pkg::slot_t exe_d [ISSUE_WIDTH];
  shi_pkg::slot_t mem_q [ISSUE_WIDTH];
  shi_pkg::slot_t mem_d [ISSUE_WIDTH];

  shi_pkg::fwd_cfg_t cfg_q, cfg_d;

  logic close_pend_q, close_pend_d;

  // result serializer
  logic                   res_busy_q, res_busy_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;
  logic [ISSUE_WIDTH-1:0] res_stall_q, res_stall_d;
  logic [ISSUE_WIDTH-1:0] res_occ_q, res_occ_d;

  logic [ISSUE_WIDTH-1:0] fin;
  logic [ISSUE_WIDTH-1:0] dec_vld;
  logic                   in_fire, out_fire, out_done, res_free, compute_fire;
  logic                   lane_ok;
  logic                   cfg_fire;
  shi_pkg::slot_t         new_slot;

  shi_hazard_check #(
    .ISSUE_WIDTH(ISSUE_WIDTH)
  ) u_check (
    .dec_i (dec_q),
    .exe_i (exe_q),
    .mem_i (mem_q),
    .cfg_i (cfg_q),
    .fin_o (fin)
  );

  // handshakes
  assign out_valid_o  = res_busy_q;
  assign out_fire     = out_valid_o && out_ready_i;
  assign out_done     = out_fire && (res_idx_q == IdxW'(ISSUE_WIDTH - 1));
  assign res_free     = !res_busy_q || out_done;
  // the closed group is evaluated once the serializer can take its results
  assign compute_fire = close_pend_q && res_free;
  // a pending close blocks new beats only until it is evaluated
  assign in_ready_o   = !close_pend_q || res_free;
  assign in_fire      = in_valid_i && in_ready_o;
  assign lane_ok      = ({1'b0, lane_i} < 4'(ISSUE_WIDTH));

  assign out_lane_o = 3'(res_idx_q);
  assign stalled_o  = res_stall_q[res_idx_q];
  assign occupied_o = res_occ_q[res_idx_q];
  assign last_o     = (res_idx_q == IdxW'(ISSUE_WIDTH - 1));

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    new_slot.valid = 1'b1;
    new_slot.ra    = src_a_reg_i;
    new_slot.rb    = src_b_reg_i;
    new_slot.rd    = dest_reg_i;
    new_slot.ua    = src_a_used_i;
    new_slot.ub    = src_b_used_i;
    new_slot.ud    = dest_used_i;
    new_slot.rf    = reads_flags_i;
    new_slot.wf    = writes_flags_i;
    new_slot.ld    = is_load_i;
    new_slot.age   = age_i;
  end

  always_comb begin
    for (int j = 0; j < ISSUE_WIDTH; j++) begin
      dec_vld[j] = dec_q[j].valid;
    end
  end

  // slot updates: on evaluation MA takes EX, EX takes the issued lanes and
  // the group buffer clears; a beat taken in the same cycle lands after that
  always_comb begin
    dec_d = dec_q;
    exe_d = exe_q;
    mem_d = mem_q;
    if (compute_fire) begin
      mem_d = exe_q;
      for (int j = 0; j < ISSUE_WIDTH; j++) begin
        exe_d[j]       = dec_q[j];
        exe_d[j].valid = dec_q[j].valid && !fin[j];
        dec_d[j].valid = 1'b0;
      end
    end
    if (in_fire && lane_ok) begin
      dec_d[lane_i[IdxW-1:0]] = new_slot;
    end
  end

  always_comb begin
    close_pend_d = close_pend_q;
    if (compute_fire) begin
      close_pend_d = 1'b0;
    end
    if (in_fire) begin
      close_pend_d = group_end_i;
    end
  end

  always_comb begin
    res_busy_d  = res_busy_q;
    res_idx_d   = res_idx_q;
    res_stall_d = res_stall_q;
    res_occ_d   = res_occ_q;
    if (out_done) begin
      res_busy_d = 1'b0;
      res_idx_d  = '0;
    end else if (out_fire) begin
      res_idx_d = res_idx_q + 1'b1;
    end
    if (compute_fire) begin
      res_busy_d  = 1'b1;
      res_idx_d   = '0;
      res_stall_d = fin;
      res_occ_d   = dec_vld;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        shi_pkg::CFG_MEM_FWD: cfg_d.mem_fwd = cfg_data_i;
        shi_pkg::CFG_EXE_FWD: cfg_d.exe_fwd = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_pend_q <= 1'b0;
      res_busy_q   <= 1'b0;
      res_idx_q    <= '0;
      cfg_q        <= '0;
      for (int j = 0; j < ISSUE_WIDTH; j++) begin
        dec_q[j].valid <= 1'b0;
        exe_q[j].valid <= 1'b0;
        mem_q[j].valid <= 1'b0;
      end
    end else begin
      close_pend_q <= close_pend_d;
      res_busy_q   <= res_busy_d;
      res_idx_q    <= res_idx_d;
      cfg_q        <= cfg_d;
      dec_q        <= dec_d;
      exe_q        <= exe_d;
      mem_q        <= mem_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    res_stall_q <= res_stall_d;
    res_occ_q   <= res_occ_d;
  end

  // evaluation always starts a fresh result run at lane zero
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compute_fire |=> (out_valid_o && out_lane_o == '0))
    else $error("result run did not start at lane zero");

  // an empty lane never reports a stall
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !occupied_o) |-> !stalled_o)
    else $error("empty lane reported as stalled");

  // the group buffer is empty after evaluation unless a new beat landed
  a_group_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (compute_fire && !in_fire) |=> ($countones(dec_vld) == 0))
    else $error("group buffer not cleared after evaluation");

  // the group buffer never changes while a closed group waits
  a_pend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (close_pend_q && !res_free) |=> (close_pend_q && $stable(dec_vld)))
    else $error("pending group changed before evaluation");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int IW        = shi_pkg::IssueWidthDef;
  localparam int LaneIdxW  = $clog2(IW);
  localparam int LaneW     = shi_pkg::LaneW;
  localparam int RegW      = shi_pkg::RegW;
  localparam int AgeW      = shi_pkg::AgeW;
  localparam int CfgIdxW   = shi_pkg::CfgIdxW;
  localparam int HOLD_CYC  = 64;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYC = 4;    // settle time once nothing is pending
  localparam int RAND_BEATS = 95;  // per forwarding setting

  // which operand of the consumer is being resolved
  typedef enum int {SRC_A, SRC_B, SRC_FLAGS} src_kind_e;
  // where the youngest older producer sits
  typedef enum int {FROM_NONE, FROM_MA, FROM_EX, FROM_GROUP} producer_e;

  // one instruction beat as driven on the input channel
  typedef struct packed {
    logic [LaneW-1:0] lane;
    logic [RegW-1:0]  ra;
    logic             ua;
    logic [RegW-1:0]  rb;
    logic             ub;
    logic [RegW-1:0]  rd;
    logic             ud;
    logic             rf;
    logic             wf;
    logic             ld;
    logic [AgeW-1:0]  age;
    logic             ge;
  } beat_t;

  // one per-lane decision as seen on the output channel
  typedef struct packed {
    logic [LaneW-1:0] lane;
    logic             stalled;
    logic             occupied;
    logic             last;
  } decision_t;

  // directed row: beat, plus hand-typed decisions for a closing beat
  typedef struct packed {
    beat_t            b;
    logic             typed;
    logic [IW-1:0]    stall_mask;
    logic [IW-1:0]    occ_mask;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic                cfg_data;

  logic                in_valid;
  logic                in_ready;
  logic [LaneW-1:0]    lane;
  logic [RegW-1:0]     src_a_reg;
  logic                src_a_used;
  logic [RegW-1:0]     src_b_reg;
  logic                src_b_used;
  logic [RegW-1:0]     dest_reg;
  logic                dest_used;
  logic                reads_flags;
  logic                writes_flags;
  logic                is_load;
  logic [AgeW-1:0]     age;
  logic                group_end;

  logic                out_valid;
  logic                out_ready;
  logic [LaneW-1:0]    out_lane;
  logic                stalled;
  logic                occupied;
  logic                last;

  // predictor state: group buffer, EX and MA occupants, forwarding enables
  shi_pkg::slot_t dec_slot [IW];
  shi_pkg::slot_t ex_slot  [IW];
  shi_pkg::slot_t ma_slot  [IW];
  logic  mem_fwd_en;
  logic  exe_fwd_en;

  decision_t decision_q [$];   // decisions still owed by the block
  dir_row_t  dir_tab [$];
  int        err_cnt;

  // shared knobs between the sender and the receiver
  bit calm;       // no idling on either side
  bit hold_req;   // receiver should hold off for HOLD_CYC cycles

  superscalar_hazard_interlock_top #(
    .ISSUE_WIDTH(IW)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .lane_i        (lane),
    .src_a_reg_i   (src_a_reg),
    .src_a_used_i  (src_a_used),
    .src_b_reg_i   (src_b_reg),
    .src_b_used_i  (src_b_used),
    .dest_reg_i    (dest_reg),
    .dest_used_i   (dest_used),
    .reads_flags_i (reads_flags),
    .writes_flags_i(writes_flags),
    .is_load_i     (is_load),
    .age_i         (age),
    .group_end_i   (group_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_lane_o    (out_lane),
    .stalled_o     (stalled),
    .occupied_o    (occupied),
    .last_o        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("ERROR: run timed out at %0t", $time);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // p writes what c reads for this operand, and p is strictly older
  function automatic logic feeds(input shi_pkg::slot_t p, input shi_pkg::slot_t c,
                                 input src_kind_e kind);
    if (!p.valid || p.age >= c.age) return 1'b0;
    case (kind)
      SRC_A:   return c.ua && p.ud && (p.rd == c.ra);
      SRC_B:   return c.ub && p.ud && (p.rd == c.rb);
      default: return c.rf && p.wf;
    endcase
  endfunction

  // Youngest older producer decides. Ties on age keep the first one met:
  // lanes upward, and per lane MA, then EX, then the group itself.
  function automatic logic operand_blocked(input int self, input src_kind_e kind);
    producer_e       best;
    logic [AgeW-1:0] best_age;
    logic            best_ld;
    shi_pkg::slot_t  p;
    producer_e       order [3];
    best     = FROM_NONE;
    best_age = '0;
    best_ld  = 1'b0;
    order    = '{FROM_MA, FROM_EX, FROM_GROUP};
    for (int j = 0; j < IW; j++) begin
      for (int k = 0; k < 3; k++) begin
        case (order[k])
          FROM_MA: p = ma_slot[j];
          FROM_EX: p = ex_slot[j];
          default: p = dec_slot[j];
        endcase
        if (order[k] == FROM_GROUP && j == self) continue;
        if (feeds(p, dec_slot[self], kind) && (best == FROM_NONE || p.age > best_age)) begin
          best     = order[k];
          best_age = p.age;
          best_ld  = p.ld;
        end
      end
    end
    case (best)
      FROM_GROUP: return 1'b1;
      FROM_EX:    return !(exe_fwd_en && !best_ld);
      FROM_MA:    return !mem_fwd_en;
      default:    return 1'b0;
    endcase
  endfunction

  // Apply one accepted beat. A closing beat resolves the group, queues one
  // decision per lane and advances the pipeline. Typed rows replace the
  // predicted decisions with hand-written ones but still advance the state.
  task automatic take_beat(input beat_t b, input logic typed,
                           input logic [IW-1:0] t_stall, input logic [IW-1:0] t_occ);
    logic [IW-1:0]       own;
    logic [IW-1:0]       fin;
    decision_t           d;
    logic [LaneIdxW-1:0] li;
    li = b.lane[LaneIdxW-1:0];
    if (b.lane < IW) begin
      dec_slot[li].valid = 1'b1;
      dec_slot[li].ra    = b.ra;
      dec_slot[li].ua    = b.ua;
      dec_slot[li].rb    = b.rb;
      dec_slot[li].ub    = b.ub;
      dec_slot[li].rd    = b.rd;
      dec_slot[li].ud    = b.ud;
      dec_slot[li].rf    = b.rf;
      dec_slot[li].wf    = b.wf;
      dec_slot[li].ld    = b.ld;
      dec_slot[li].age   = b.age;
    end
    if (!b.ge) return;

    for (int i = 0; i < IW; i++)
      own[i] = dec_slot[i].valid && (operand_blocked(i, SRC_A) ||
               operand_blocked(i, SRC_B) || operand_blocked(i, SRC_FLAGS));
    fin = own;
    // in-order issue: anything younger than a stalled lane stalls as well
    for (int i = 0; i < IW; i++) begin
      if (!own[i]) continue;
      for (int j = 0; j < IW; j++)
        if (dec_slot[j].valid && dec_slot[j].age > dec_slot[i].age) fin[j] = 1'b1;
    end

    for (int i = 0; i < IW; i++) begin
      d.lane     = LaneW'(i);
      d.stalled  = typed ? t_stall[i] : fin[i];
      d.occupied = typed ? t_occ[i] : dec_slot[i].valid;
      d.last     = (i == IW - 1);
      decision_q.push_back(d);
    end

    ma_slot = ex_slot;
    for (int i = 0; i < IW; i++) begin
      ex_slot[i]       = dec_slot[i];
      ex_slot[i].valid = dec_slot[i].valid && !fin[i];
      dec_slot[i]      = '0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Both forwarding enables back to back; valid stays up between the beats.
  task automatic apply_cfg(input logic mem_on, input logic exe_on);
    cfg_valid <= 1'b1;
    cfg_index <= shi_pkg::CFG_MEM_FWD;
    cfg_data  <= mem_on;
    do @(posedge clk); while (!cfg_ready);
    mem_fwd_en = mem_on;
    cfg_index <= shi_pkg::CFG_EXE_FWD;
    cfg_data  <= exe_on;
    do @(posedge clk); while (!cfg_ready);
    exe_fwd_en = exe_on;
    cfg_valid <= 1'b0;
  endtask

  // Offer one beat, optionally after a random gap, and hold it until taken.
  task automatic send_beat(input beat_t b, input logic typed,
                           input logic [IW-1:0] t_stall, input logic [IW-1:0] t_occ);
    if (!calm && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    lane         <= b.lane;
    src_a_reg    <= b.ra;
    src_a_used   <= b.ua;
    src_b_reg    <= b.rb;
    src_b_used   <= b.ub;
    dest_reg     <= b.rd;
    dest_used    <= b.ud;
    reads_flags  <= b.rf;
    writes_flags <= b.wf;
    is_load      <= b.ld;
    age          <= b.age;
    group_end    <= b.ge;
    do @(posedge clk); while (!in_ready);
    take_beat(b, typed, t_stall, t_occ);
  endtask

  // wait until every owed decision has come out, then let the block settle
  task automatic drain();
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // small register pool most of the time so dependencies actually occur
  function automatic logic [RegW-1:0] pick_reg();
    logic [RegW-1:0] r;
    if ($urandom_range(99) < 85) r = RegW'($urandom_range(7));
    else                         r = RegW'($urandom_range(255));
    return r;
  endfunction

  function automatic beat_t random_beat(input logic [AgeW-1:0] base);
    beat_t b;
    b.lane = LaneW'($urandom_range(IW - 1));
    b.ra   = pick_reg();
    b.ua   = ($urandom_range(99) < 75);
    b.rb   = pick_reg();
    b.ub   = ($urandom_range(99) < 75);
    b.rd   = pick_reg();
    b.ud   = ($urandom_range(99) < 70);
    b.rf   = ($urandom_range(99) < 30);
    b.wf   = ($urandom_range(99) < 30);
    b.ld   = ($urandom_range(99) < 25);
    b.age  = base;
    b.ge   = 1'b0;
    return b;
  endfunction

  // Mostly well-formed groups (lanes upward, ages in program order) with
  // random content; the rest is noise: stray lanes, random ages, random
  // closing. Dropped beats that close nothing are not counted.
  task automatic play_random(input int n_beats);
    int              sent;
    int              top_lane;
    logic [AgeW-1:0] age_ctr;
    logic [IW-1:0]   mask;
    beat_t           b;
    sent    = 0;
    age_ctr = $urandom();
    while (sent < n_beats) begin
      if ($urandom_range(99) < 80) begin
        mask = IW'($urandom_range(1, (1 << IW) - 1));
        top_lane = 0;
        for (int l = 0; l < IW; l++) if (mask[l]) top_lane = l;
        for (int l = 0; l < IW; l++) begin
          if (!mask[l]) continue;
          if ($urandom_range(99) < 5) begin
            // beat later overwritten by a second one for the same lane
            b = random_beat($urandom());
            b.lane = LaneW'(l);
            send_beat(b, 1'b0, '0, '0);
            sent++;
          end
          if ($urandom_range(99) < 15) b = random_beat(age_ctr + $urandom_range(IW - 1));
          else                         b = random_beat(age_ctr + AgeW'(l));
          b.lane = LaneW'(l);
          b.ge   = (l == top_lane);
          send_beat(b, 1'b0, '0, '0);
          sent++;
        end
        age_ctr += AgeW'(IW) + AgeW'($urandom_range(2));
      end else begin
        b      = random_beat($urandom());
        b.lane = LaneW'($urandom_range(7));
        b.ra   = RegW'($urandom_range(255));
        b.rb   = RegW'($urandom_range(255));
        b.rd   = RegW'($urandom_range(255));
        b.ge   = 1'($urandom_range(1));
        send_beat(b, 1'b0, '0, '0);
        if (b.lane < IW || b.ge) sent++;
      end
    end
    // close whatever is open so the block ends the phase idle
    b    = random_beat(age_ctr);
    b.ge = 1'b1;
    send_beat(b, 1'b0, '0, '0);
    in_valid <= 1'b0;
  endtask

  function automatic dir_row_t row(
    input logic ge, input logic [LaneW-1:0] ln, input logic [AgeW-1:0] ag,
    input logic [RegW-1:0] ra, input logic ua, input logic [RegW-1:0] rb, input logic ub,
    input logic [RegW-1:0] rd, input logic ud, input logic rf, input logic wf,
    input logic ld, input logic typed, input logic [IW-1:0] st, input logic [IW-1:0] oc);
    dir_row_t r;
    r.b          = '{lane: ln, ra: ra, ua: ua, rb: rb, ub: ub, rd: rd, ud: ud,
                     rf: rf, wf: wf, ld: ld, age: ag, ge: ge};
    r.typed      = typed;
    r.stall_mask = st;
    r.occ_mask   = oc;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random ready, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every decision beat against the oldest owed decision
  // ---------------------------------------------------------------------
  initial begin
    decision_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          report_mismatch($sformatf("decision beat lane %0d with nothing owed", out_lane));
        end else begin
          want = decision_q.pop_front();
          if (out_lane !== want.lane)
            report_mismatch($sformatf("out_lane %0d, want %0d", out_lane, want.lane));
          if (stalled !== want.stalled)
            report_mismatch($sformatf("lane %0d stalled %b, want %b",
                                      want.lane, stalled, want.stalled));
          if (occupied !== want.occupied)
            report_mismatch($sformatf("lane %0d occupied %b, want %b",
                                      want.lane, occupied, want.occupied));
          if (last !== want.last)
            report_mismatch($sformatf("lane %0d last %b, want %b", want.lane, last, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic phase_mem [4];
    logic phase_exe [4];

    err_cnt  = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    mem_fwd_en = 1'b0;
    exe_fwd_en = 1'b0;
    for (int i = 0; i < IW; i++) begin
      dec_slot[i] = '0;
      ex_slot[i]  = '0;
      ma_slot[i]  = '0;
    end
    // forwarding settings of the random phases; both extremes included
    phase_mem = '{1'b1, 1'b0, 1'b1, 1'b0};
    phase_exe = '{1'b1, 1'b1, 1'b0, 1'b0};

    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= shi_pkg::CFG_MEM_FWD;
    cfg_data  <= 1'b0;
    in_valid  <= 1'b0;
    {lane, src_a_reg, src_a_used, src_b_reg, src_b_used, dest_reg, dest_used,
     reads_flags, writes_flags, is_load, age, group_end} <= '0;

    // Directed table. Columns: group_end, lane, age, src_a, a_used, src_b,
    // b_used, dest, d_used, reads_flags, writes_flags, is_load, typed,
    // stall mask, occupied mask (lane 0 on the right). Forwarding is off.
    // dropped lane with every field at its top still closes an empty group
    dir_tab.push_back(row(1, 7, 32'hFFFF_FFFF, 255, 1, 255, 1, 255, 1, 1, 1, 1,
                          1, 4'b0000, 4'b0000));
    // lone instruction after reset, nothing to depend on
    dir_tab.push_back(row(1, 0, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 4'b0000, 4'b0001));
    // producer in the same group always stalls
    dir_tab.push_back(row(0, 0, 20, 0, 0, 0, 0, 5, 1, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 1, 21, 5, 1, 0, 0, 0, 0, 0, 0, 0, 1, 4'b0010, 4'b0011));
    // producer now in EX, EX forwarding off
    dir_tab.push_back(row(1, 0, 30, 5, 1, 0, 0, 0, 0, 0, 0, 0, 1, 4'b0001, 4'b0001));
    // same producer now in MA via src_b, MA forwarding off
    dir_tab.push_back(row(1, 2, 40, 0, 0, 5, 1, 0, 0, 0, 0, 0, 1, 4'b0100, 4'b0100));
    // extremes and register zero, younger lane stalls behind a stalled one
    dir_tab.push_back(row(0, 3, 32'hFFFF_FFFF, 255, 1, 255, 1, 255, 1, 1, 1, 1,
                          0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(0, 1, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 2, 2, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    // condition codes: in group, then from EX
    dir_tab.push_back(row(0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 1, 101, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 0, 110, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 4'b0000, 4'b0000));
    // lane offered twice: the second beat replaces the producer
    dir_tab.push_back(row(0, 1, 200, 0, 0, 0, 0, 9, 1, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(0, 1, 201, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 2, 202, 9, 1, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    // equal ages: not strictly older, no hazard
    dir_tab.push_back(row(0, 0, 300, 0, 0, 0, 0, 3, 1, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 1, 300, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    // load in EX
    dir_tab.push_back(row(1, 0, 400, 0, 0, 0, 0, 7, 1, 0, 0, 1, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 0, 401, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    // dropped lanes only, closed by another dropped lane
    dir_tab.push_back(row(0, 5, 500, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 4, 501, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 4'b0000, 4'b0000));
    // ages out of lane order: lane 0 is youngest and follows lane 1's stall
    dir_tab.push_back(row(0, 3, 600, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(0, 2, 650, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(0, 1, 700, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 4'b0000, 4'b0000));
    dir_tab.push_back(row(1, 0, 800, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    apply_cfg(1'b0, 1'b0);
    foreach (dir_tab[i])
      send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].stall_mask, dir_tab[i].occ_mask);
    in_valid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      drain();
      apply_cfg(phase_mem[p], phase_exe[p]);
      hold_req = (p == 1);   // back-pressure until the input stalls
      calm     = (p == 2);   // a phase with no idling at all
      play_random(RAND_BEATS);
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("PASS");
    else              $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/shi_pkg.sv
hw/rtl/shi_hazard_check.sv
hw/rtl/superscalar_hazard_interlock_top.sv
sim/tb_top.sv
